// ===== rtl/pbalc_pkg.sv =====
package pbalc_pkg;

    localparam int CNT_W = 10;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_PAGE  = 2'd1,
        ST_TOO_BIG  = 2'd2,
        ST_UNOWNED  = 2'd3
    } status_t;

    typedef enum logic {
        KIND_ALLOC = 1'b0,
        KIND_FREE  = 1'b1
    } kind_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_POOL_WAIT,
        S_CARVE,
        S_POP_WAIT,
        S_FREE_WAIT,
        S_WALK,
        S_WALK_RD,
        S_OUT
    } state_t;

    typedef struct packed {
        logic        kind;
        logic [13:0] request_size;
        logic [18:0] block_address;
    } req_t;

    typedef struct packed {
        logic [18:0] address;
        logic [1:0]  status;
        logic        page_returned;
    } rsp_t;

endpackage

// ===== rtl/pbalc_size_class.sv =====
module pbalc_size_class import pbalc_pkg::*; #(
    parameter int PAGE_BYTES   = 8192,
    parameter int SIZE_CLASSES = 9,
    parameter int MIN_SHIFT    = 4,
    localparam int CW = $clog2(SIZE_CLASSES + 1)
) (
    input  logic [13:0]   size,
    output logic [CW-1:0] cls,
    output logic          whole,
    output logic          oversize
);
    localparam longint MAX_BLOCK = longint'(1) << (MIN_SHIFT + SIZE_CLASSES - 1);

    logic [31:0] sz;

    assign sz = 32'(size);

    // smallest class whose block holds the size; compares are independent
    always_comb begin
        cls = '0;
        for (int k = 0; k < SIZE_CLASSES - 1; k++) begin
            if ((longint'(1) << (MIN_SHIFT + k)) < longint'(sz)) begin
                cls = CW'(k + 1);
            end
        end
    end

    assign oversize = sz > 32'(PAGE_BYTES);
    assign whole    = (sz > 32'(PAGE_BYTES / 2)) || (longint'(sz) > MAX_BLOCK);

endmodule

// ===== rtl/pbalc_link_ram.sv =====
module pbalc_link_ram import pbalc_pkg::*; #(
    parameter int AW = 15,
    parameter int DW = 20
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);
    logic [DW-1:0] mem [2**AW];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/power_of_two_block_allocator_top.sv =====
// Power-of-two block allocator: one result word per request word. A request
// is taken only in idle, and the next one only after its result is taken.
// An error result (size too large, no free page, unowned page) is decided in
// decode and is valid in the cycle after it. An allocate from a class list,
// a whole-page allocate or a free that keeps its page passes through decode
// and one registered read of link/count/pool memories before its result is
// valid. Carving a fresh page writes one link word per block after the first.
// A free that empties a class page walks its class list, one S_WALK and
// S_WALK_RD pair per entry, the walk capped at one step per link entry; a
// whole page is freed from the free-wait state. A stalled result holds the
// block until it is taken. Link and page memories hold no reset contents;
// pool entries not yet written are tracked by valid bits, so no clearing
// pass is needed after reset.
module power_of_two_block_allocator_top import pbalc_pkg::*; #(
    parameter int PAGE_BYTES   = 8192,
    parameter int NUM_PAGES    = 64,
    parameter int SIZE_CLASSES = 9,
    parameter int MIN_SHIFT    = 4
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  req_t s_data,
    output logic m_valid,
    input  logic m_ready,
    output rsp_t m_data
);
    localparam int PG_W  = $clog2(NUM_PAGES);
    localparam int PSH   = $clog2(PAGE_BYTES);
    localparam int AW    = PG_W + PSH;
    localparam int LAW   = AW - MIN_SHIFT;
    localparam int CW    = $clog2(SIZE_CLASSES + 1);
    localparam int HIW   = $clog2(SIZE_CLASSES);
    localparam int TOP_W = PG_W + 1;

    state_t state_reg, state_next;
    req_t   req_reg, req_next;
    rsp_t   res_reg, res_next;
    logic   whole_reg, whole_next;
    logic [CW-1:0]    cls_reg, cls_next;
    logic [PG_W-1:0]  page_reg, page_next;
    logic [AW:0]      cur_reg, cur_next;
    logic [AW:0]      limit_reg, limit_next;
    logic [AW:0]      bs_reg, bs_next;
    logic [AW:0]      ptr_reg, ptr_next;
    logic [AW:0]      fresh_reg, fresh_next;
    logic [LAW:0]     steps_reg, steps_next;
    logic [TOP_W-1:0] top_reg, top_next;
    logic [AW:0]      heads_reg [SIZE_CLASSES];
    logic [AW:0]      heads_next [SIZE_CLASSES];
    logic [NUM_PAGES-1:0] busy_reg, busy_next;
    logic [NUM_PAGES-1:0] pvld_reg, pvld_next;

    // page memories
    logic [CNT_W-1:0] cnt_mem [NUM_PAGES];
    logic [CW-1:0]    pcls_mem [NUM_PAGES];
    logic [PG_W-1:0]  pool_mem [NUM_PAGES];
    logic [CNT_W-1:0] cnt_rd_reg;
    logic [CW-1:0]    pcls_rd_reg;
    logic [PG_W-1:0]  pool_rd_reg, pool_ridx_reg;
    logic             pool_rvld_reg;
    logic             cnt_we, pcls_we, pool_we;
    logic [PG_W-1:0]  meta_widx, meta_ridx, pool_widx, pool_ridx;
    logic [CNT_W-1:0] cnt_wdata;
    logic [CW-1:0]    pcls_wdata;

    logic           link_we;
    logic [LAW-1:0] link_widx, link_ridx;
    logic [AW:0]    link_wdata, link_rdata;

    logic [CW-1:0]  sc_cls;
    logic           sc_whole, sc_over;

    logic [18:0]     fpage;
    logic [PG_W-1:0] pop_page;
    logic [AW:0]     base, fbs, aligned;
    logic [CNT_W-1:0] cnt_dec;
    logic [AW-1:0]   hd_addr;

    function automatic logic [AW:0] base_of(input logic [PG_W-1:0] pg);
        return {1'b0, pg, PSH'(0)};
    endfunction

    pbalc_size_class #(
        .PAGE_BYTES  (PAGE_BYTES),
        .SIZE_CLASSES(SIZE_CLASSES),
        .MIN_SHIFT   (MIN_SHIFT)
    ) u_size_class (
        .size    (req_reg.request_size),
        .cls     (sc_cls),
        .whole   (sc_whole),
        .oversize(sc_over)
    );

    pbalc_link_ram #(.AW(LAW), .DW(AW + 1)) u_link_ram (
        .aclk (aclk),
        .we   (link_we),
        .waddr(link_widx),
        .wdata(link_wdata),
        .raddr(link_ridx),
        .rdata(link_rdata)
    );

    always_ff @(posedge aclk) begin
        if (cnt_we) begin
            cnt_mem[meta_widx] <= cnt_wdata;
        end
        if (pcls_we) begin
            pcls_mem[meta_widx] <= pcls_wdata;
        end
        if (pool_we) begin
            pool_mem[pool_widx] <= page_reg;
        end
        cnt_rd_reg    <= cnt_mem[meta_ridx];
        pcls_rd_reg   <= pcls_mem[meta_ridx];
        pool_rd_reg   <= pool_mem[pool_ridx];
        pool_rvld_reg <= pvld_reg[pool_ridx];
        pool_ridx_reg <= pool_ridx;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_OUT);
    assign m_data  = res_reg;

    assign fpage    = req_reg.block_address >> PSH;
    // unwritten pool entries stand for page NUM_PAGES-1 minus their index
    assign pop_page = pool_rvld_reg ? pool_rd_reg
                                    : PG_W'(NUM_PAGES - 1) - pool_ridx_reg;
    assign base     = {1'b0, pop_page, PSH'(0)};
    assign fbs      = (AW + 1)'(1) << (MIN_SHIFT + int'(pcls_rd_reg));
    assign aligned  = {1'b0, AW'(req_reg.block_address)} & ~(fbs - (AW + 1)'(1));
    assign cnt_dec  = cnt_rd_reg - CNT_W'(1);
    assign hd_addr  = heads_reg[sc_cls[HIW-1:0]][AW-1:0];

    always_comb begin
        state_next = state_reg;
        req_next   = req_reg;
        res_next   = res_reg;
        whole_next = whole_reg;
        cls_next   = cls_reg;
        page_next  = page_reg;
        cur_next   = cur_reg;
        limit_next = limit_reg;
        bs_next    = bs_reg;
        ptr_next   = ptr_reg;
        fresh_next = fresh_reg;
        steps_next = steps_reg;
        top_next   = top_reg;
        heads_next = heads_reg;
        busy_next  = busy_reg;
        pvld_next  = pvld_reg;
        cnt_we     = 1'b0;
        pcls_we    = 1'b0;
        pool_we    = 1'b0;
        meta_widx  = page_reg;
        meta_ridx  = page_reg;
        cnt_wdata  = CNT_W'(1);
        pcls_wdata = cls_reg;
        pool_widx  = top_reg[PG_W-1:0];
        pool_ridx  = PG_W'(top_reg - TOP_W'(1));
        link_we    = 1'b0;
        link_widx  = cur_reg[AW-1:MIN_SHIFT];
        link_wdata = cur_reg + bs_reg;
        link_ridx  = cur_reg[AW-1:MIN_SHIFT];

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    req_next   = s_data;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                res_next = '{address: '0, status: ST_OK, page_returned: 1'b0};
                cls_next = sc_cls;
                if (req_reg.kind == KIND_ALLOC) begin
                    if (sc_over) begin
                        res_next.status = ST_TOO_BIG;
                        state_next      = S_OUT;
                    end else if (!sc_whole && heads_reg[sc_cls[HIW-1:0]][AW]) begin
                        cur_next   = {1'b0, hd_addr};
                        page_next  = hd_addr[AW-1:PSH];
                        meta_ridx  = hd_addr[AW-1:PSH];
                        link_ridx  = hd_addr[AW-1:MIN_SHIFT];
                        state_next = S_POP_WAIT;
                    end else if (top_reg == '0) begin
                        res_next.status = ST_NO_PAGE;
                        state_next      = S_OUT;
                    end else begin
                        whole_next = sc_whole;
                        state_next = S_POOL_WAIT;
                    end
                end else begin
                    if (fpage >= 19'(NUM_PAGES) || !busy_reg[fpage[PG_W-1:0]]) begin
                        res_next.status = ST_UNOWNED;
                        state_next      = S_OUT;
                    end else begin
                        page_next  = fpage[PG_W-1:0];
                        meta_ridx  = fpage[PG_W-1:0];
                        state_next = S_FREE_WAIT;
                    end
                end
            end
            S_POOL_WAIT: begin
                top_next            = top_reg - TOP_W'(1);
                page_next           = pop_page;
                meta_widx           = pop_page;
                busy_next[pop_page] = 1'b1;
                cnt_we              = 1'b1;
                pcls_we             = 1'b1;
                pcls_wdata          = whole_reg ? CW'(SIZE_CLASSES) : cls_reg;
                res_next.address    = 19'(base);
                if (whole_reg) begin
                    state_next = S_OUT;
                end else begin
                    bs_next    = (AW + 1)'(1) << (MIN_SHIFT + int'(cls_reg));
                    cur_next   = base + ((AW + 1)'(1) << (MIN_SHIFT + int'(cls_reg)));
                    limit_next = base + (AW + 1)'(PAGE_BYTES)
                               - ((AW + 1)'(1) << (MIN_SHIFT + int'(cls_reg)));
                    state_next = S_CARVE;
                end
            end
            S_CARVE: begin
                link_we = 1'b1;
                if (cur_reg < limit_reg) begin
                    link_wdata = {1'b1, AW'(cur_reg + bs_reg)};
                    cur_next   = cur_reg + bs_reg;
                end else begin
                    // last block chains onto the old list
                    link_wdata = heads_reg[cls_reg[HIW-1:0]];
                    heads_next[cls_reg[HIW-1:0]] = {1'b1, AW'(base_of(page_reg) + bs_reg)};
                    state_next = S_OUT;
                end
            end
            S_POP_WAIT: begin
                cnt_we    = 1'b1;
                cnt_wdata = cnt_rd_reg + CNT_W'(1);
                heads_next[cls_reg[HIW-1:0]] = link_rdata;
                res_next.address = 19'(cur_reg);
                state_next = S_OUT;
            end
            S_FREE_WAIT: begin
                cnt_we    = 1'b1;
                cnt_wdata = cnt_dec;
                cls_next  = pcls_rd_reg;
                if (cnt_dec != '0) begin
                    if (pcls_rd_reg < CW'(SIZE_CLASSES)) begin
                        link_we    = 1'b1;
                        link_widx  = aligned[AW-1:MIN_SHIFT];
                        link_wdata = heads_reg[pcls_rd_reg[HIW-1:0]];
                        heads_next[pcls_rd_reg[HIW-1:0]] = {1'b1, aligned[AW-1:0]};
                    end
                    state_next = S_OUT;
                end else if (pcls_rd_reg < CW'(SIZE_CLASSES)) begin
                    ptr_next   = heads_reg[pcls_rd_reg[HIW-1:0]];
                    fresh_next = '0;
                    steps_next = '0;
                    state_next = S_WALK;
                end else begin
                    busy_next[page_reg] = 1'b0;
                    if (top_reg < TOP_W'(NUM_PAGES)) begin
                        pool_we            = 1'b1;
                        pvld_next[top_reg[PG_W-1:0]] = 1'b1;
                        top_next           = top_reg + TOP_W'(1);
                    end
                    res_next.page_returned = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_WALK: begin
                if (ptr_reg[AW] && !steps_reg[LAW]) begin
                    cur_next   = {1'b0, ptr_reg[AW-1:0]};
                    link_ridx  = ptr_reg[AW-1:MIN_SHIFT];
                    state_next = S_WALK_RD;
                end else begin
                    heads_next[cls_reg[HIW-1:0]] = fresh_reg;
                    busy_next[page_reg] = 1'b0;
                    if (top_reg < TOP_W'(NUM_PAGES)) begin
                        pool_we            = 1'b1;
                        pvld_next[top_reg[PG_W-1:0]] = 1'b1;
                        top_next           = top_reg + TOP_W'(1);
                    end
                    res_next.page_returned = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_WALK_RD: begin
                ptr_next   = link_rdata;
                steps_next = steps_reg + (LAW + 1)'(1);
                // survivors are relinked onto a fresh list, reversing order
                if (cur_reg[AW-1:PSH] != page_reg) begin
                    link_we    = 1'b1;
                    link_wdata = fresh_reg;
                    fresh_next = {1'b1, cur_reg[AW-1:0]};
                end
                state_next = S_WALK;
            end
            S_OUT: begin
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            top_reg   <= TOP_W'(NUM_PAGES);
            busy_reg  <= '0;
            pvld_reg  <= '0;
            for (int i = 0; i < SIZE_CLASSES; i++) begin
                heads_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            top_reg   <= top_next;
            busy_reg  <= busy_next;
            pvld_reg  <= pvld_next;
            heads_reg <= heads_next;
        end
        req_reg   <= req_next;
        res_reg   <= res_next;
        whole_reg <= whole_next;
        cls_reg   <= cls_next;
        page_reg  <= page_next;
        cur_reg   <= cur_next;
        limit_reg <= limit_next;
        bs_reg    <= bs_next;
        ptr_reg   <= ptr_next;
        fresh_reg <= fresh_next;
        steps_reg <= steps_next;
    end

endmodule
